[src/nibble_map_brush_painter_defines.svh]
// ----------------------------------------------------------------------------
// Nibble map brush painter assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_MAP_BRUSH_PAINTER_DEFINES_SVH
`define NIBBLE_MAP_BRUSH_PAINTER_DEFINES_SVH

// Consequent holds in the cycle after the antecedent, outside reset.
`define NMBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmbp: next-cycle check failed");

// Consequent holds in the cycle after reset is seen high.
`define NMBP_ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("nmbp: reset check failed");

`endif

[src/nmbp_pkg.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter package
// Shared types, field widths and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nmbp_pkg;

  localparam int unsigned LAYERS  = 4;
  localparam int unsigned LAYER_W = 2;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned WIDTH_W = 9;
  localparam int unsigned RAW_W   = 17;
  localparam int unsigned WORD_W  = LAYERS * BYTE_W;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned TDATA_W = 32;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [LAYER_W-1:0] LAYER_TOP = 2'd3;

  localparam logic [2:0] REG_ADD_DENS   = 3'd0;
  localparam logic [2:0] REG_ADD_HGT    = 3'd1;
  localparam logic [2:0] REG_AFF_DENS   = 3'd2;
  localparam logic [2:0] REG_AFF_HGT    = 3'd3;
  localparam logic [2:0] REG_BRUSH_HGT  = 3'd4;
  localparam logic [2:0] REG_BRUSH_DENS = 3'd5;
  localparam logic [2:0] REG_CUR_LAYER  = 3'd6;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd7;

  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_DRAG  = 2'd1,
    MODE_END   = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_t;

  typedef struct packed {
    logic               add_density_mode;
    logic               add_height_mode;
    logic               dens_en;
    logic               hgt_en;
    logic [NIB_W-1:0]   brush_height;
    logic [NIB_W-1:0]   brush_density;
    logic [LAYER_W-1:0] current_layer;
    logic [WIDTH_W-1:0] map_width;
  } cfg_t;

  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LAYER_W-1:0] lay_first;
    logic [LAYER_W-1:0] lay_last;
    logic               sub;
    logic [BYTE_W-1:0]  value;
  } cmd_t;

endpackage

`default_nettype wire

[src/nmbp_fifo.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter command queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module nmbp_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output logic [W-1:0]      head_data
);
  import nmbp_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  logic [W-1:0]  slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == (PW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/nmbp_front.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter front
// Accepts words, tracks the stroke, forms cell addresses and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nmbp_front #(
  parameter int unsigned MAP_SIDE = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire nmbp_pkg::cfg_t                  cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire nmbp_pkg::mode_t                 mode,
  input  wire logic [nmbp_pkg::COORD_W-1:0]    pos_x,
  input  wire logic [nmbp_pkg::COORD_W-1:0]    pos_y,
  input  wire logic                            on_map,
  input  wire logic                            all_layers,
  input  wire logic                            subtract,
  input  wire logic [nmbp_pkg::LAYER_W-1:0]    load_layer,
  input  wire logic [nmbp_pkg::BYTE_W-1:0]     load_value,
  output logic                                 q_push,
  output nmbp_pkg::cmd_t                       q_cmd,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] q_cell,
  input  wire logic                            q_full
);
  import nmbp_pkg::*;

  localparam int unsigned CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int unsigned CW     = $clog2(CELLS);
  localparam int unsigned RCP_W  = 31;
  localparam int unsigned PROD_W = RAW_W + RCP_W;
  localparam int unsigned Q_W    = PROD_W - 32;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << 32) / CELLS);

  logic               drawing;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;
  logic               last_known;

  logic              v0, v1, v2;
  cmd_t              cmd0, cmd1, cmd2;
  logic [RAW_W-1:0]  raw0, raw1, rem2;
  logic [PROD_W-1:0] prod1;

  logic             adv;
  logic             accept;
  logic             affect_any;
  logic             same_cell;
  logic             paint;
  logic             keep;
  cmd_t             cmd_in;
  logic [RAW_W-1:0] raw_in;
  logic [Q_W-1:0]   quot;
  logic [31:0]      rem_wide;

  assign adv        = !(v2 && q_full);
  assign in_ready   = adv;
  assign accept     = in_valid && adv;
  assign affect_any = cfg.dens_en || cfg.hgt_en;
  assign same_cell  = last_known && (last_x == pos_x) && (last_y == pos_y);

  always_comb begin
    paint = 1'b0;
    case (mode)
      MODE_BEGIN: paint = on_map && affect_any;
      MODE_DRAG:  paint = drawing && on_map && affect_any && !same_cell;
      default:    paint = 1'b0;
    endcase
  end

  assign keep = paint || (mode == MODE_LOAD);

  always_comb begin
    cmd_in.is_load   = (mode == MODE_LOAD);
    cmd_in.x         = pos_x;
    cmd_in.y         = pos_y;
    cmd_in.sub       = subtract;
    cmd_in.value     = load_value;
    cmd_in.lay_last  = all_layers ? LAYER_TOP : cfg.current_layer;
    if (mode == MODE_LOAD) begin
      cmd_in.lay_first = load_layer;
    end else begin
      cmd_in.lay_first = all_layers ? '0 : cfg.current_layer;
    end
  end

  assign raw_in   = RAW_W'(RAW_W'(pos_y) * RAW_W'(cfg.map_width)) + RAW_W'(pos_x);
  assign quot     = prod1[PROD_W-1:32];
  assign rem_wide = 32'(rem2);

  assign q_push = v2;
  assign q_cmd  = cmd2;
  assign q_cell = CW'((rem_wide >= CELLS) ? (rem_wide - CELLS) : rem_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing    <= 1'b0;
      last_x     <= '0;
      last_y     <= '0;
      last_known <= 1'b0;
      v0         <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (accept) begin
        case (mode)
          MODE_BEGIN: begin
            drawing    <= 1'b1;
            last_known <= paint;
          end
          MODE_END: drawing <= 1'b0;
          default: begin
            if (paint) begin
              last_known <= 1'b1;
            end
          end
        endcase
        if (paint) begin
          last_x <= pos_x;
          last_y <= pos_y;
        end
      end
      if (adv) begin
        v0 <= accept && keep;
        v1 <= v0;
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0  <= cmd_in;
      raw0  <= raw_in;
      cmd1  <= cmd0;
      raw1  <= raw0;
      prod1 <= PROD_W'(raw0) * PROD_W'(RECIP);
      cmd2  <= cmd1;
      rem2  <= raw1 - RAW_W'(32'(quot) * CELLS);
    end
  end

endmodule

`default_nettype wire

[src/nmbp_back.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter back
// Holds the map memory and runs load writes and paint read-modify-writes.
// ----------------------------------------------------------------------------
`default_nettype none

module nmbp_back #(
  parameter int unsigned MAP_SIDE = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire nmbp_pkg::cfg_t                       cfg,
  input  wire logic                                 q_valid,
  input  wire nmbp_pkg::cmd_t                       q_cmd,
  input  wire logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] q_cell,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [nmbp_pkg::COORD_W-1:0]              out_x,
  output logic [nmbp_pkg::COORD_W-1:0]              out_y,
  output logic [nmbp_pkg::LAYER_W-1:0]              out_layer,
  output logic [nmbp_pkg::BYTE_W-1:0]               cell_value,
  output logic                                      last_of_run
);
  import nmbp_pkg::*;

  localparam int unsigned CELLS = MAP_SIDE * MAP_SIDE;
  localparam int unsigned CW    = $clog2(CELLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EMIT
  } state_t;

  function automatic logic [NIB_W-1:0] apply_nib(input logic [NIB_W-1:0] v,
                                                 input logic [NIB_W-1:0] amt,
                                                 input logic add_mode,
                                                 input logic sub);
    logic [NIB_W:0] sum;
    begin
      sum = {1'b0, v} + {1'b0, amt};
      if (!add_mode) begin
        return amt;
      end else if (sub) begin
        return (v >= amt) ? (v - amt) : '0;
      end else begin
        return sum[NIB_W] ? '1 : sum[NIB_W-1:0];
      end
    end
  endfunction

  logic [WORD_W-1:0]  mem [CELLS];
  logic [WORD_W-1:0]  rdata;

  state_t             state;
  cmd_t               cmd;
  logic [CW-1:0]      cmd_cell;
  logic [WORD_W-1:0]  new_word;
  logic [LAYER_W-1:0] lay;

  logic               mem_we;
  logic [LAYERS-1:0]  mem_be;
  logic [CW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mod_word;
  logic [LAYERS-1:0]  mod_be;
  logic               out_free;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_comb begin
    logic [NIB_W-1:0]   h;
    logic [NIB_W-1:0]   d;
    logic [LAYER_W-1:0] l2;
    for (int l = 0; l < LAYERS; l++) begin
      l2 = LAYER_W'(l);
      h  = rdata[BYTE_W*l+NIB_W +: NIB_W];
      d  = rdata[BYTE_W*l +: NIB_W];
      if (cfg.dens_en) begin
        d = apply_nib(d, cfg.brush_density, cfg.add_density_mode, cmd.sub);
      end
      if (cfg.hgt_en) begin
        h = apply_nib(h, cfg.brush_height, cfg.add_height_mode, cmd.sub);
      end
      mod_word[BYTE_W*l +: BYTE_W] = {h, d};
      mod_be[l] = (l2 >= cmd.lay_first) && (l2 <= cmd.lay_last);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_be    = '0;
    mem_addr  = q_cell;
    mem_wdata = {LAYERS{q_cmd.value}};
    case (state)
      ST_IDLE: begin
        if (q_valid && q_cmd.is_load) begin
          mem_we = 1'b1;
          mem_be = LAYERS'(1) << q_cmd.lay_first;
        end
      end
      ST_MOD: begin
        mem_we    = 1'b1;
        mem_be    = mod_be;
        mem_addr  = cmd_cell;
        mem_wdata = mod_word;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < LAYERS; b++) begin
        if (mem_be[b]) begin
          mem[mem_addr][BYTE_W*b +: BYTE_W] <= mem_wdata[BYTE_W*b +: BYTE_W];
        end
      end
    end
    rdata <= mem[q_cell];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == ST_EMIT) || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (q_valid && !q_cmd.is_load) begin
            cmd      <= q_cmd;
            cmd_cell <= q_cell;
            state    <= ST_MOD;
          end
        end
        ST_MOD: begin
          new_word <= mod_word;
          lay      <= cmd.lay_first;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_x       <= cmd.x;
            out_y       <= cmd.y;
            out_layer   <= lay;
            cell_value  <= new_word[{lay, 3'b000} +: BYTE_W];
            last_of_run <= (lay == cmd.lay_last);
            if (lay == cmd.lay_last) begin
              state <= ST_IDLE;
            end else begin
              lay <= lay + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/nibble_map_brush_painter.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter
// Four-layer nibble map with load and brush stroke painting.
//
//   port group   dir   direction of flow   contents
//   s_*          in    stream slave        load, begin, drag and end words
//   m_*          out   stream master       one word per rewritten layer byte
//   p*           in    register port       brush and map settings
//
// The front takes a word each cycle while its queue has room; address forming
// multiplies by a reciprocal, then subtracts. A load is written while the back
// idles; a paint reads, modifies and emits one word per layer before it pops again.
// Reset clears control state only; the map holds garbage until loaded.
// A full output register stalls the back, and a full queue stalls s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_map_brush_painter #(
  parameter int unsigned MAP_SIDE = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // pos_x, pos_y, on_map, all_layers, subtract, load_layer, load_value, pad
  input  wire logic [nmbp_pkg::TDATA_W-1:0]    s_tdata,
  // mode
  input  wire logic [nmbp_pkg::LAYER_W-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // out_x, out_y, out_layer, cell_value, pad
  output logic [nmbp_pkg::TDATA_W-1:0]         m_tdata,
  output logic                                 m_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nmbp_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import nmbp_pkg::*;

  localparam int unsigned CW = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int unsigned QW = CW + $bits(cmd_t);

  cfg_t               cfg;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  logic               f_push;
  cmd_t               f_cmd;
  logic [CW-1:0]      f_cell;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic [QW-1:0]      q_data;
  cmd_t               b_cmd;
  logic [CW-1:0]      b_cell;

  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [LAYER_W-1:0] out_layer;
  logic [BYTE_W-1:0]  cell_value;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.add_density_mode <= 1'b0;
      cfg.add_height_mode  <= 1'b0;
      cfg.dens_en          <= 1'b1;
      cfg.hgt_en           <= 1'b1;
      cfg.brush_height     <= 4'd8;
      cfg.brush_density    <= 4'd8;
      cfg.current_layer    <= '0;
      cfg.map_width        <= 9'd256;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_ADD_DENS:   cfg.add_density_mode <= pwdata[0];
        REG_ADD_HGT:    cfg.add_height_mode  <= pwdata[0];
        REG_AFF_DENS:   cfg.dens_en          <= pwdata[0];
        REG_AFF_HGT:    cfg.hgt_en           <= pwdata[0];
        REG_BRUSH_HGT:  cfg.brush_height     <= pwdata[NIB_W-1:0];
        REG_BRUSH_DENS: cfg.brush_density    <= pwdata[NIB_W-1:0];
        REG_CUR_LAYER:  cfg.current_layer    <= pwdata[LAYER_W-1:0];
        REG_MAP_WIDTH:  cfg.map_width        <= pwdata[WIDTH_W-1:0];
        default:        cfg.map_width        <= cfg.map_width;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADD_DENS:   prdata = 32'(cfg.add_density_mode);
      REG_ADD_HGT:    prdata = 32'(cfg.add_height_mode);
      REG_AFF_DENS:   prdata = 32'(cfg.dens_en);
      REG_AFF_HGT:    prdata = 32'(cfg.hgt_en);
      REG_BRUSH_HGT:  prdata = 32'(cfg.brush_height);
      REG_BRUSH_DENS: prdata = 32'(cfg.brush_density);
      REG_CUR_LAYER:  prdata = 32'(cfg.current_layer);
      REG_MAP_WIDTH:  prdata = 32'(cfg.map_width);
      default:        prdata = '0;
    endcase
  end

  nmbp_front #(
    .MAP_SIDE (MAP_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (mode_t'(s_tuser)),
    .pos_x      (s_tdata[7:0]),
    .pos_y      (s_tdata[15:8]),
    .on_map     (s_tdata[16]),
    .all_layers (s_tdata[17]),
    .subtract   (s_tdata[18]),
    .load_layer (s_tdata[20:19]),
    .load_value (s_tdata[28:21]),
    .q_push     (f_push),
    .q_cmd      (f_cmd),
    .q_cell     (f_cell),
    .q_full     (q_full)
  );

  nmbp_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  ({f_cell, f_cmd}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign b_cmd  = cmd_t'(q_data[$bits(cmd_t)-1:0]);
  assign b_cell = q_data[QW-1:$bits(cmd_t)];

  nmbp_back #(
    .MAP_SIDE (MAP_SIDE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (b_cmd),
    .q_cell      (b_cell),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_layer   (out_layer),
    .cell_value  (cell_value),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {6'b0, cell_value, out_layer, out_y, out_x};

endmodule

`default_nettype wire

[src/nmbp_checker.sv]
// ----------------------------------------------------------------------------
// Nibble map brush painter port checker
// Watches the result stream for reset, stall and run behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nibble_map_brush_painter_defines.svh"

module nmbp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  `NMBP_ASSERT_RESET(a_reset_idle, clk, rst, !m_tvalid)
  `NMBP_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `NMBP_ASSERT_NEXT(a_run_layer, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[17:16] == 2'($past(m_tdata[17:16]) + 2'd1)))
  `NMBP_ASSERT_NEXT(a_run_cell, clk, rst, m_tvalid && m_tready && !m_tlast, m_tdata[15:0] == $past(m_tdata[15:0]))

endmodule

bind nibble_map_brush_painter nmbp_checker u_nmbp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nibble map brush painter testbench
// Loads map bytes, runs brush strokes under a range of register settings and
// checks every painted layer byte against a cycle-free predictor of the map.
// A directed plan covers stroke open/close rules, repeat cells, saturation
// and a brush that touches no nibble. Random strokes follow. Paints only land
// on cells whose four layer bytes were loaded first.
// ----------------------------------------------------------------------------

module tb_top;
  import nmbp_pkg::*;

  localparam int unsigned MAP_BYTES = 256 * 256 * LAYERS;
  localparam int unsigned TAIL      = 40;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LAYER_W-1:0] layer;
    logic [BYTE_W-1:0]  value;
    logic               last;
  } painted_t;

  typedef struct {
    logic        is_reg;
    logic [2:0]  reg_idx;
    mode_t       mode;
    logic [31:0] word;
    int          n_exp;
    logic [7:0]  val_exp;
  } plan_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = MODE_END;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  nibble_map_brush_painter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predicted map and stroke state
  logic [7:0] map_mem [MAP_BYTES];
  bit         primed [MAP_BYTES];
  logic       stroke_open  = 1'b0;
  logic       cursor_known = 1'b0;
  logic [7:0] cursor_x     = '0;
  logic [7:0] cursor_y     = '0;
  cfg_t       cfg;
  painted_t   painted_q [$];

  int errors       = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int send_idle    = 0;
  int recv_idle    = 0;
  logic [7:0] spot_x [6];
  logic [7:0] spot_y [6];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 40) $display("%0t ns: %s", $time, what);
  endtask

  function automatic logic [31:0] brush_word(input logic [7:0] x, input logic [7:0] y,
                                             input logic on, input logic all,
                                             input logic sub, input logic [1:0] lay,
                                             input logic [7:0] val);
    return {3'b000, val, lay, sub, all, on, y, x};
  endfunction

  function automatic int unsigned byte_addr(input logic [7:0] x, input logic [7:0] y,
                                            input logic [1:0] lay);
    int unsigned cell_idx;
    cell_idx = (int'(y) * int'(cfg.map_width) + int'(x)) % 65536;
    return cell_idx * LAYERS + int'(lay);
  endfunction

  function automatic logic [3:0] brush_nibble(input logic [3:0] v, input logic [3:0] amt,
                                              input logic add_mode, input logic sub);
    if (!add_mode) return amt;
    if (sub) return (v >= amt) ? v - amt : 4'd0;
    return (({1'b0, v} + {1'b0, amt}) > 5'd15) ? 4'hf : v + amt;
  endfunction

  task automatic paint_cell(input logic [7:0] x, input logic [7:0] y, input logic all,
                            input logic sub, output painted_t res [4], output int n);
    int lo;
    int hi;
    int unsigned a;
    logic [3:0] h;
    logic [3:0] dn;
    n = 0;
    if (!cfg.dens_en && !cfg.hgt_en) return;
    if (cursor_known && cursor_x == x && cursor_y == y) return;
    lo = all ? 0 : int'(cfg.current_layer);
    hi = all ? 3 : int'(cfg.current_layer);
    for (int l = lo; l <= hi; l++) begin
      a  = byte_addr(x, y, 2'(l));
      h  = map_mem[a][7:4];
      dn = map_mem[a][3:0];
      if (cfg.dens_en)
        dn = brush_nibble(dn, cfg.brush_density, cfg.add_density_mode, sub);
      if (cfg.hgt_en)
        h = brush_nibble(h, cfg.brush_height, cfg.add_height_mode, sub);
      map_mem[a] = {h, dn};
      res[n] = '{x: x, y: y, layer: 2'(l), value: {h, dn}, last: (l == hi)};
      n++;
    end
    cursor_x     = x;
    cursor_y     = y;
    cursor_known = 1'b1;
  endtask

  task automatic predict_word(input mode_t m, input logic [31:0] d,
                              output painted_t res [4], output int n);
    n = 0;
    case (m)
      MODE_BEGIN: begin
        stroke_open  = 1'b1;
        cursor_known = 1'b0;
        if (d[16]) paint_cell(d[7:0], d[15:8], d[17], d[18], res, n);
      end
      MODE_DRAG: begin
        if (stroke_open && d[16]) paint_cell(d[7:0], d[15:8], d[17], d[18], res, n);
      end
      MODE_END: begin
        stroke_open = 1'b0;
      end
      default: begin
        map_mem[byte_addr(d[7:0], d[15:8], d[20:19])] = d[28:21];
      end
    endcase
  endtask

  // drive one word, then predict it once accepted
  task automatic push_word(input mode_t m, input logic [31:0] d, input int n_exp,
                           input logic [7:0] val_exp);
    painted_t res [4];
    int n;
    if (m == MODE_LOAD) primed[byte_addr(d[7:0], d[15:8], d[20:19])] = 1'b1;
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= m;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    predict_word(m, d, res, n);
    if (n_exp >= 0 && n != n_exp)
      flag_error($sformatf("plan row gives %0d results, predictor %0d", n_exp, n));
    for (int i = 0; i < n; i++) begin
      if (n_exp >= 0) res[i].value = val_exp;
      painted_q.push_back(res[i]);
    end
  endtask

  task automatic settle(input int tail);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (painted_q.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ADD_DENS:   cfg.add_density_mode = val[0];
      REG_ADD_HGT:    cfg.add_height_mode  = val[0];
      REG_AFF_DENS:   cfg.dens_en          = val[0];
      REG_AFF_HGT:    cfg.hgt_en           = val[0];
      REG_BRUSH_HGT:  cfg.brush_height     = val[3:0];
      REG_BRUSH_DENS: cfg.brush_density    = val[3:0];
      REG_CUR_LAYER:  cfg.current_layer    = val[1:0];
      default:        cfg.map_width        = val[8:0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    reg_write(REG_ADD_DENS,   32'(c.add_density_mode));
    reg_write(REG_ADD_HGT,    32'(c.add_height_mode));
    reg_write(REG_AFF_DENS,   32'(c.dens_en));
    reg_write(REG_AFF_HGT,    32'(c.hgt_en));
    reg_write(REG_BRUSH_HGT,  32'(c.brush_height));
    reg_write(REG_BRUSH_DENS, 32'(c.brush_density));
    reg_write(REG_CUR_LAYER,  32'(c.current_layer));
    reg_write(REG_MAP_WIDTH,  32'(c.map_width));
  endtask

  // load any layer byte of the cell not yet written
  task automatic prime_cell(input logic [7:0] x, input logic [7:0] y);
    for (int l = 0; l < LAYERS; l++)
      if (!primed[byte_addr(x, y, 2'(l))])
        push_word(MODE_LOAD, brush_word(x, y, 1'($urandom), 1'($urandom), 1'($urandom),
                                        2'(l), 8'($urandom)), -1, 8'h00);
  endtask

  task automatic send_brush(input mode_t m, input logic [7:0] x, input logic [7:0] y,
                            input logic on);
    if (on && m != MODE_END) prime_cell(x, y);
    push_word(m, brush_word(x, y, on, $urandom_range(2) == 0, 1'($urandom),
                            2'($urandom), 8'($urandom)), -1, 8'h00);
  endtask

  task automatic pick_spot(inout logic [7:0] x, inout logic [7:0] y);
    int k;
    if ($urandom_range(3) == 0) begin
      x = 8'($urandom);
      y = 8'($urandom);
    end else begin
      k = $urandom_range(5);
      x = spot_x[k];
      y = spot_y[k];
    end
  endtask

  task automatic random_stroke();
    logic [7:0] x;
    logic [7:0] y;
    int drags;
    mode_t m;
    x = 8'($urandom);
    y = 8'($urandom);
    if ($urandom_range(99) < 15) begin
      m = mode_t'($urandom_range(3));
      if (m == MODE_LOAD)
        push_word(m, brush_word(x, y, 1'($urandom), 1'($urandom), 1'($urandom),
                                2'($urandom), 8'($urandom)), -1, 8'h00);
      else
        send_brush(m, x, y, 1'($urandom));
      return;
    end
    pick_spot(x, y);
    send_brush(MODE_BEGIN, x, y, $urandom_range(9) != 0);
    drags = $urandom_range(1, 7);
    repeat (drags) begin
      if ($urandom_range(9) >= 2) pick_spot(x, y);
      send_brush(MODE_DRAG, x, y, $urandom_range(9) != 0);
    end
    if ($urandom_range(9) != 0) send_brush(MODE_END, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    painted_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (painted_q.size() == 0) begin
        flag_error($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
      end else begin
        e = painted_q.pop_front();
        if (m_tdata[7:0] != e.x)
          flag_error($sformatf("out_x %0d, want %0d", m_tdata[7:0], e.x));
        if (m_tdata[15:8] != e.y)
          flag_error($sformatf("out_y %0d, want %0d", m_tdata[15:8], e.y));
        if (m_tdata[17:16] != e.layer)
          flag_error($sformatf("out_layer %0d, want %0d", m_tdata[17:16], e.layer));
        if (m_tdata[25:18] != e.value)
          flag_error($sformatf("cell_value %h, want %h", m_tdata[25:18], e.value));
        if (m_tlast != e.last)
          flag_error($sformatf("last_of_run %b, want %b", m_tlast, e.last));
      end
    end
  end

  function automatic plan_row_t word_row(input mode_t m, input logic [31:0] d, input int n,
                                         input logic [7:0] v);
    return '{is_reg: 1'b0, reg_idx: REG_ADD_DENS, mode: m, word: d, n_exp: n, val_exp: v};
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] v);
    return '{is_reg: 1'b1, reg_idx: idx, mode: MODE_END, word: v, n_exp: 0, val_exp: 8'h00};
  endfunction

  initial begin
    plan_row_t plan [$];
    cfg_t c;
    int target;
    cfg = '{add_density_mode: 1'b0, add_height_mode: 1'b0, dens_en: 1'b1,
            hgt_en: 1'b1, brush_height: 4'd8, brush_density: 4'd8,
            current_layer: 2'd0, map_width: 9'd256};
    plan = '{
      word_row(MODE_LOAD,  brush_word(0, 0, 0, 0, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(0, 0, 0, 0, 0, 1, 8'hff), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(0, 0, 0, 0, 0, 2, 8'h5a), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(0, 0, 0, 0, 0, 3, 8'hf0), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(255, 255, 0, 0, 0, 0, 8'h0f), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(255, 255, 0, 0, 0, 1, 8'ha5), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(255, 255, 0, 0, 0, 2, 8'h3c), 0, 8'h00),
      word_row(MODE_LOAD,  brush_word(255, 255, 0, 0, 0, 3, 8'hff), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(0, 0, 1, 0, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_END,   brush_word(0, 0, 0, 0, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_BEGIN, brush_word(0, 0, 1, 0, 0, 0, 8'h00), 1, 8'h88),
      word_row(MODE_DRAG,  brush_word(0, 0, 1, 1, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(255, 255, 0, 1, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(255, 255, 1, 1, 0, 0, 8'h00), 4, 8'h88),
      word_row(MODE_BEGIN, brush_word(255, 255, 0, 0, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(255, 255, 1, 0, 0, 0, 8'h00), 1, 8'h88),
      word_row(MODE_END,   brush_word(255, 255, 1, 1, 1, 3, 8'hff), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(0, 0, 1, 0, 0, 0, 8'h00), 0, 8'h00),
      reg_row(REG_ADD_DENS, 32'd1),
      reg_row(REG_ADD_HGT, 32'd1),
      reg_row(REG_BRUSH_HGT, 32'd15),
      reg_row(REG_BRUSH_DENS, 32'd15),
      word_row(MODE_BEGIN, brush_word(0, 0, 1, 1, 0, 0, 8'h00), 4, 8'hff),
      word_row(MODE_DRAG,  brush_word(255, 255, 1, 1, 1, 0, 8'h00), 4, 8'h00),
      reg_row(REG_AFF_DENS, 32'd0),
      reg_row(REG_AFF_HGT, 32'd0),
      word_row(MODE_DRAG,  brush_word(0, 0, 1, 1, 0, 0, 8'h00), 0, 8'h00),
      reg_row(REG_AFF_HGT, 32'd1),
      word_row(MODE_DRAG,  brush_word(255, 255, 1, 1, 0, 0, 8'h00), 0, 8'h00),
      word_row(MODE_DRAG,  brush_word(0, 0, 1, 0, 1, 0, 8'h00), 1, 8'h0f),
      word_row(MODE_END,   brush_word(0, 0, 0, 0, 0, 0, 8'h00), 0, 8'h00)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 21;
    recv_idle = 82;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle(TAIL);
        reg_write(plan[i].reg_idx, plan[i].word);
      end else begin
        push_word(plan[i].mode, plan[i].word, plan[i].n_exp, plan[i].val_exp);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 21 : (ph < 4) ? 82 : 0;
      recv_idle = (ph < 2) ? 82 : (ph < 4) ? 21 : 0;
      case (ph)
        0: c = '{1'b0, 1'b0, 1'b1, 1'b1, 4'd0, 4'd15, 2'd2, 9'd256};
        1: c = '{1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 4'd15, 2'd3, 9'd1};
        2: c = '{1'b1, 1'b0, 1'b1, 1'b0, 4'd7, 4'd0, 2'd1, 9'd511};
        3: c = '{1'b0, 1'b1, 1'b0, 1'b1, 4'd3, 4'd9, 2'd0, 9'd0};
        default: c = '{1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       4'($urandom), 4'($urandom), 2'($urandom),
                       9'($urandom_range(1, 256))};
      endcase
      settle(TAIL);
      load_settings(c);
      spot_x[0] = 8'd0;
      spot_y[0] = 8'd0;
      spot_x[1] = 8'd255;
      spot_y[1] = 8'd255;
      for (int k = 2; k < 6; k++) begin
        spot_x[k] = 8'($urandom);
        spot_y[k] = 8'($urandom);
      end
      target = words_sent + 48;
      while (words_sent < target) begin
        random_stroke();
        // hold the stream until the map catches up
        if (ph == 2 && words_sent >= target - 24 && words_sent < target - 16) settle(0);
      end
    end

    settle(TAIL);
    $display("Sent %0d words over 7 register settings, incl. directed stroke cases;",
             words_sent);
    $display("checked %0d painted layer words.", results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/nmbp_pkg.sv
src/nmbp_fifo.sv
src/nmbp_front.sv
src/nmbp_back.sv
src/nibble_map_brush_painter.sv
src/nmbp_checker.sv
test/tb_top.sv
